### rtl/hrv_pkg.sv
// Package for the RMSSD heart rate variability engine.
// Sizes, limits and derived widths shared by the sequencer and its arithmetic units.
// No dependencies.
package hrv_pkg;

    localparam int INTERVAL_DEPTH = 30;
    localparam int HISTORY_DEPTH  = 20;

    localparam int RR_W      = 11;
    localparam int RMSSD_W   = 13;
    localparam int PCT_W     = 7;
    localparam int FUNC_W    = 1;
    localparam int RR_IN_W   = 16;

    localparam int RR_MIN        = 300;
    localparam int RR_MAX        = 2000;
    localparam int MIN_INTERVALS = 3;
    localparam int MIN_DIFFS     = 2;
    localparam int PCT_SCALE     = 100;
    localparam int PCT_RESET     = 20;
    localparam int RMSSD_MAX     = 8191;
    localparam int FRAC_BITS     = 8;

    localparam int IA_W = (INTERVAL_DEPTH > 1) ? $clog2(INTERVAL_DEPTH) : 1;
    localparam int IC_W = $clog2(INTERVAL_DEPTH + 1);
    localparam int HA_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HC_W = $clog2(HISTORY_DEPTH + 1);

    localparam int PROD_W  = RR_W + PCT_W;
    localparam int SQ_D_W  = 2 * RR_W;
    localparam int SUM_W   = SQ_D_W + IC_W;
    localparam int MS_W    = SUM_W + FRAC_BITS;
    localparam int HS_W    = RMSSD_W + HC_W;
    localparam int DIVD_W  = (MS_W > HS_W) ? MS_W : HS_W;
    localparam int DVS_W   = (IC_W > HC_W) ? IC_W : HC_W;
    localparam int SQ_IN_W = DIVD_W + (DIVD_W % 2);
    localparam int SQ_OUT_W = SQ_IN_W / 2;

    localparam logic [FUNC_W-1:0] FUNC_BEAT  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 1'b1;

endpackage

### rtl/hrv_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on hrv_pkg for the dividend and divisor widths.
module hrv_div import hrv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DIVD_W-1:0] r_quo;

    logic [DVS_W:0] w_trial;
    logic [DVS_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### rtl/hrv_sqrt.sv
// Integer square root, one result bit per cycle, floored.
// Depends on hrv_pkg for the operand and root widths.
module hrv_sqrt import hrv_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SQ_IN_W-1:0]  i_value,
    output logic                o_done,
    output logic [SQ_OUT_W-1:0] o_root
);
    localparam int CNT_W = $clog2(SQ_OUT_W + 1);
    localparam int RW    = SQ_OUT_W + 3;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [SQ_IN_W-1:0]  r_val;
    logic [RW-1:0]       r_rem;
    logic [SQ_OUT_W-1:0] r_root;

    logic [RW-1:0] w_t;
    logic [RW-1:0] w_trial;
    logic          w_ge;

    assign w_t     = {r_rem[RW-3:0], r_val[SQ_IN_W-1:SQ_IN_W-2]};
    assign w_trial = RW'({r_root, 2'b01});
    assign w_ge    = w_t >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SQ_OUT_W);
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val  <= {r_val[SQ_IN_W-3:0], 2'b00};
                r_rem  <= w_ge ? (w_t - w_trial) : w_t;
                r_root <= {r_root[SQ_OUT_W-2:0], w_ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/hrv_rmssd_engine.sv
// RMSSD engine: a beat request runs the steps below before the next request is accepted.
// Steps: a walk over the stored intervals, a divide with 35 quotient bits, a square root,
// a walk over the history and a second divide through the same divider, plus sequencing.
// A clear request empties both stores and goes straight to the output state.
// A stalled result holds the sequencer in its last state.
// Depends on hrv_pkg, hrv_div and hrv_sqrt.
module hrv_rmssd_engine import hrv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [RR_IN_W-1:0] i_rr_ms,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_rmssd_valid,
    output logic [RMSSD_W-1:0] o_rmssd,
    output logic               o_hrv_valid,
    output logic [RMSSD_W-1:0] o_hrv,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [PCT_W-1:0]   i_cfg_data
);
    localparam int SW = IC_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_W_START, S_W_RD, S_W_DAT, S_W_ACC, S_W_DIV, S_W_DIVW, S_W_SQW,
        S_H_START, S_H_RD, S_H_DAT, S_H_DIV, S_H_DIVW, S_DONE
    } t_state;

    t_state             r_state;
    logic [PCT_W-1:0]   r_pct;
    logic [RR_W-1:0]    r_imem [INTERVAL_DEPTH];
    logic [RMSSD_W-1:0] r_hmem [HISTORY_DEPTH];
    logic [RR_W-1:0]    r_idata;
    logic [RMSSD_W-1:0] r_hdata;
    logic [IC_W-1:0]    r_icount;
    logic [IA_W-1:0]    r_ihead;
    logic [HC_W-1:0]    r_hcount;
    logic [HA_W-1:0]    r_hhead;
    logic [IA_W-1:0]    r_ptr;
    logic [IC_W-1:0]    r_idx;
    logic [RR_W-1:0]    r_prev;
    logic [RR_W-1:0]    r_d;
    logic               r_ok;
    logic [SUM_W-1:0]   r_sum;
    logic [IC_W-1:0]    r_used;
    logic [HC_W-1:0]    r_hidx;
    logic [HS_W-1:0]    r_hsum;
    logic               r_div_start;
    logic [DIVD_W-1:0]  r_div_dvd;
    logic [DVS_W-1:0]   r_div_dvs;
    logic               r_sq_start;
    logic [SQ_IN_W-1:0] r_sq_in;
    logic               r_rvalid;
    logic [RMSSD_W-1:0] r_rmssd;
    logic               r_hvalid;
    logic [RMSSD_W-1:0] r_hrv;
    logic               r_out_valid;
    logic               r_out_rvalid;
    logic [RMSSD_W-1:0] r_out_rmssd;
    logic               r_out_hvalid;
    logic [RMSSD_W-1:0] r_out_hrv;

    logic                w_accept;
    logic                w_in_range;
    logic                w_iwe;
    logic                w_hwe;
    logic                w_div_done;
    logic [DIVD_W-1:0]   w_div_quot;
    logic                w_sq_done;
    logic [SQ_OUT_W-1:0] w_sq_root;
    logic [RMSSD_W-1:0]  w_rmssd_sat;
    logic [RR_W-1:0]     w_d;
    logic                w_ok;
    logic [SW-1:0]       w_start_sum;
    logic [IA_W-1:0]     w_start;

    assign w_accept   = i_valid && !o_stall;
    assign w_in_range = (i_rr_ms >= RR_IN_W'(RR_MIN)) && (i_rr_ms <= RR_IN_W'(RR_MAX));
    assign w_iwe      = w_accept && (i_func == FUNC_BEAT) && w_in_range;
    assign w_hwe      = (r_state == S_W_SQW) && w_sq_done;

    assign w_rmssd_sat = (w_sq_root > SQ_OUT_W'(RMSSD_MAX)) ? RMSSD_W'(RMSSD_MAX)
                                                            : w_sq_root[RMSSD_W-1:0];
    assign w_d  = (r_idata >= r_prev) ? (r_idata - r_prev) : (r_prev - r_idata);
    assign w_ok = (PROD_W'(w_d) * PROD_W'(PCT_SCALE)) <= (PROD_W'(r_pct) * PROD_W'(r_prev));

    assign w_start_sum = SW'(r_ihead) + SW'(INTERVAL_DEPTH) - SW'(r_icount);
    assign w_start     = (w_start_sum >= SW'(INTERVAL_DEPTH))
                         ? IA_W'(w_start_sum - SW'(INTERVAL_DEPTH)) : IA_W'(w_start_sum);

    hrv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    hrv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_value (r_sq_in),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_iwe) begin
            r_imem[r_ihead] <= i_rr_ms[RR_W-1:0];
        end
        r_idata <= r_imem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_hmem[r_hhead] <= w_rmssd_sat;
        end
        r_hdata <= r_hmem[r_hidx[HA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pct       <= PCT_W'(PCT_RESET);
            r_icount    <= '0;
            r_ihead     <= '0;
            r_hcount    <= '0;
            r_hhead     <= '0;
            r_div_start <= 1'b0;
            r_sq_start  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
            r_hidx      <= '0;
        end else begin
            r_div_start <= 1'b0;
            r_sq_start  <= 1'b0;
            if (i_cfg_valid) begin
                r_pct <= i_cfg_data;
            end
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rvalid <= 1'b0;
                        r_rmssd  <= '0;
                        r_hvalid <= 1'b0;
                        r_hrv    <= '0;
                        if (i_func == FUNC_CLEAR) begin
                            r_icount <= '0;
                            r_ihead  <= '0;
                            r_hcount <= '0;
                            r_hhead  <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            if (w_in_range) begin
                                r_ihead <= (r_ihead == IA_W'(INTERVAL_DEPTH - 1))
                                           ? '0 : r_ihead + IA_W'(1);
                                if (r_icount != IC_W'(INTERVAL_DEPTH)) begin
                                    r_icount <= r_icount + IC_W'(1);
                                end
                            end
                            r_state <= S_W_START;
                        end
                    end
                end
                S_W_START: begin
                    if (r_icount < IC_W'(MIN_INTERVALS)) begin
                        r_state <= S_H_START;
                    end else begin
                        r_ptr   <= w_start;
                        r_idx   <= '0;
                        r_sum   <= '0;
                        r_used  <= '0;
                        r_state <= S_W_RD;
                    end
                end
                S_W_RD: begin
                    r_state <= S_W_DAT;
                end
                S_W_DAT: begin
                    r_prev <= r_idata;
                    r_d    <= w_d;
                    r_ok   <= w_ok;
                    r_idx  <= r_idx + IC_W'(1);
                    r_ptr  <= (r_ptr == IA_W'(INTERVAL_DEPTH - 1)) ? '0 : r_ptr + IA_W'(1);
                    r_state <= (r_idx == '0) ? S_W_RD : S_W_ACC;
                end
                S_W_ACC: begin
                    if (r_ok) begin
                        r_sum  <= r_sum + SUM_W'(SQ_D_W'(r_d) * SQ_D_W'(r_d));
                        r_used <= r_used + IC_W'(1);
                    end
                    r_state <= (r_idx == r_icount) ? S_W_DIV : S_W_RD;
                end
                S_W_DIV: begin
                    if (r_used < IC_W'(MIN_DIFFS)) begin
                        r_state <= S_H_START;
                    end else begin
                        r_div_dvd   <= DIVD_W'({r_sum, FRAC_BITS'(0)});
                        r_div_dvs   <= DVS_W'(r_used);
                        r_div_start <= 1'b1;
                        r_state     <= S_W_DIVW;
                    end
                end
                S_W_DIVW: begin
                    if (w_div_done) begin
                        r_sq_in    <= SQ_IN_W'(w_div_quot);
                        r_sq_start <= 1'b1;
                        r_state    <= S_W_SQW;
                    end
                end
                S_W_SQW: begin
                    if (w_sq_done) begin
                        r_rmssd  <= w_rmssd_sat;
                        r_rvalid <= 1'b1;
                        r_hhead  <= (r_hhead == HA_W'(HISTORY_DEPTH - 1))
                                    ? '0 : r_hhead + HA_W'(1);
                        if (r_hcount != HC_W'(HISTORY_DEPTH)) begin
                            r_hcount <= r_hcount + HC_W'(1);
                        end
                        r_state <= S_H_START;
                    end
                end
                S_H_START: begin
                    if (r_hcount == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_hidx  <= '0;
                        r_hsum  <= '0;
                        r_state <= S_H_RD;
                    end
                end
                S_H_RD: begin
                    r_state <= S_H_DAT;
                end
                S_H_DAT: begin
                    r_hsum  <= r_hsum + HS_W'(r_hdata);
                    r_hidx  <= r_hidx + HC_W'(1);
                    r_state <= (r_hidx + HC_W'(1) == r_hcount) ? S_H_DIV : S_H_RD;
                end
                S_H_DIV: begin
                    r_div_dvd   <= DIVD_W'(r_hsum);
                    r_div_dvs   <= DVS_W'(r_hcount);
                    r_div_start <= 1'b1;
                    r_state     <= S_H_DIVW;
                end
                S_H_DIVW: begin
                    if (w_div_done) begin
                        r_hrv    <= w_div_quot[RMSSD_W-1:0];
                        r_hvalid <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_rvalid <= r_rvalid;
                        r_out_rmssd  <= r_rmssd;
                        r_out_hvalid <= r_hvalid;
                        r_out_hrv    <= r_hrv;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_rmssd_valid = r_out_rvalid;
    assign o_rmssd       = r_out_rmssd;
    assign o_hrv_valid   = r_out_hvalid;
    assign o_hrv         = r_out_hrv;

    a_icount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_icount <= IC_W'(INTERVAL_DEPTH))
        else $error("interval count above depth");

    a_hcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcount <= HC_W'(HISTORY_DEPTH))
        else $error("history count above depth");

    a_rmssd_implies_hrv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rmssd_valid) |-> o_hrv_valid)
        else $error("rmssd valid without history");

    a_rmssd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rmssd_valid) |-> (o_rmssd == '0))
        else $error("invalid rmssd not zero");

    a_hist_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hwe |=> (r_hcount != '0))
        else $error("history push left count empty");

endmodule
